>>> rtl/sint_pkg.sv
// Package for the spread symbol interleaver: shared constants, register
// indexes, group size helper and the address generator control types.
// No dependencies.
package sint_pkg;

  // group store
  localparam int BUF_DEPTH = 12;
  localparam int ADDR_W    = 4;
  localparam int LEN_W     = 12;
  localparam int CFG_W     = 3;

  // configuration register indexes
  localparam logic [0:0] REG_SPREAD_FACTOR = 1'd0;
  localparam logic [0:0] REG_DIRECTION     = 1'd1;

  // reset values
  localparam logic [CFG_W-1:0] FACTOR_RESET = 3'd2;

  // factors that permute
  localparam logic [CFG_W-1:0] FACTOR_TWO  = 3'd2;
  localparam logic [CFG_W-1:0] FACTOR_FOUR = 3'd4;
  localparam logic [CFG_W-1:0] ROWS_TWO    = 3'd2;
  localparam logic [CFG_W-1:0] ROWS_THREE  = 3'd3;

  // symbols in one group: rows times factor
  function automatic logic [ADDR_W-1:0] group_size(input logic f4, input logic rows3);
    logic [ADDR_W-1:0] g;
    case ({f4, rows3})
      2'b00:   g = 4'd4;
      2'b01:   g = 4'd6;
      2'b10:   g = 4'd8;
      2'b11:   g = 4'd12;
      default: g = 4'd4;
    endcase
    return g;
  endfunction

  // address generator control and status
  typedef struct packed {
    logic load;    // start a new group read-out
    logic step;    // one read issued
    logic f4;      // factor is four
    logic rows3;   // group has three rows
    logic dir;     // 1 deinterleave
  } ag_ctrl_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              last;
  } ag_stat_t;

endpackage

>>> rtl/sint_if.sv
// Stream interfaces for the spread symbol interleaver: input symbol
// channel and result channel, each with valid/ready. Depends on sint_pkg.
interface sint_in_if import sint_pkg::*; #(parameter int SAMPLE_WIDTH = 16);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;
  logic                           packet_start;
  logic [LEN_W-1:0]               packet_length;

  modport source (output valid, sample, packet_start, packet_length, input ready);
  modport sink   (input valid, sample, packet_start, packet_length, output ready);
endinterface

interface sint_out_if #(parameter int SAMPLE_WIDTH = 16);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_out;
  logic                           group_last;
  logic                           packet_last;

  modport source (output valid, sample_out, group_last, packet_last, input ready);
  modport sink   (input valid, sample_out, group_last, packet_last, output ready);
endinterface

>>> rtl/spread_symbol_interleaver.sv
// Spread symbol interleaver top level: packet control, group fill, read-out
// and output register. Depends on sint_pkg, sint_if, sint_group_mem, sint_addr_gen.
//
// Symbols are taken one per cycle. Pass-through symbols (factor other than
// 2 or 4, symbols outside a packet, a trailing partial group) leave through
// the output register in the following cycle. Permuted symbols are written
// into a 12-entry group store; once a group of g symbols (4, 6, 8 or 12) is
// complete, input is held off while the store is read out, one symbol per
// cycle through its single read port; the last read lands in the registered
// read data of the store before it reaches the output register.
// Factor and direction are sampled at packet start; a new packet drops any
// partly filled group. Output backpressure stalls both fill and read-out.
module spread_symbol_interleaver import sint_pkg::*; #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int MAX_PACKET   = 4096
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [0:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  sint_in_if.sink          in_chan,
  sint_out_if.source       out_chan
);

  localparam int LW = $clog2(MAX_PACKET + 1);
  localparam int CW = (LW > LEN_W) ? LW : LEN_W;

  localparam logic ST_FILL  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  // configuration and packet state
  logic [CFG_W-1:0]  reg_factor_r;
  logic              reg_dir_r;
  logic [CFG_W-1:0]  pkt_factor_r, pkt_factor_nxt;
  logic              pkt_dir_r, pkt_dir_nxt;
  logic [LW-1:0]     left_r, left_nxt;
  logic [ADDR_W-1:0] fill_r, fill_nxt;
  logic              rows3_r, rows3_nxt;
  logic              state_r, state_nxt;
  logic              drain_pl_r, drain_pl_nxt;

  // read-out and output stage
  logic                    pend_r, pend_nxt;
  logic                    pend_last_r;
  logic                    out_v_r, out_v_nxt;
  logic [SAMPLE_WIDTH-1:0] out_data_r;
  logic                    out_gl_r, out_pl_r;

  // effective values for the symbol being taken
  logic [CW-1:0]     len_w, len_c;
  logic [CFG_W-1:0]  f_eff;
  logic              dir_eff;
  logic [LW-1:0]     left_eff;
  logic [ADDR_W-1:0] fill_eff, g_eff;
  logic              rows3_eff, permutes, take_group, group_done, pass_last, in_pkt;

  logic     can_load, in_ready, in_fire, issue, pend_take;
  logic     mem_we;
  ag_ctrl_t ag_ctrl;
  ag_stat_t ag_stat;
  logic [SAMPLE_WIDTH-1:0] mem_rdata;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reg_factor_r <= FACTOR_RESET;
      reg_dir_r    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SPREAD_FACTOR: reg_factor_r <= cfg_data;
        REG_DIRECTION:     reg_dir_r    <= cfg_data[0];
        default:           reg_dir_r    <= reg_dir_r;
      endcase
    end
  end

  // handshake
  assign can_load  = !out_v_r || out_chan.ready;
  assign in_ready  = (state_r == ST_FILL) && !pend_r && can_load;
  assign in_fire   = in_chan.valid && in_ready;
  assign issue     = (state_r == ST_DRAIN) && (!pend_r || can_load);
  assign pend_take = pend_r && can_load;

  // packet start overrides the latched packet state
  assign len_w = CW'(in_chan.packet_length);
  assign len_c = (len_w > CW'(MAX_PACKET)) ? CW'(MAX_PACKET) : len_w;

  always_comb begin
    if (in_chan.packet_start) begin
      f_eff     = reg_factor_r;
      dir_eff   = reg_dir_r;
      left_eff  = LW'(len_c);
      fill_eff  = '0;
      rows3_eff = (reg_factor_r == FACTOR_TWO  && len_c[1]) ||
                  (reg_factor_r == FACTOR_FOUR && len_c[2]);
    end else begin
      f_eff     = pkt_factor_r;
      dir_eff   = pkt_dir_r;
      left_eff  = left_r;
      fill_eff  = fill_r;
      rows3_eff = rows3_r;
    end
  end

  assign permutes   = (f_eff == FACTOR_TWO) || (f_eff == FACTOR_FOUR);
  assign g_eff      = group_size(f_eff == FACTOR_FOUR, rows3_eff);
  assign in_pkt     = (left_eff != '0);
  assign take_group = in_pkt && permutes &&
                      ((fill_eff != '0) || (left_eff >= LW'(g_eff)));
  assign group_done = take_group && (fill_eff + 4'd1 == g_eff);
  assign pass_last  = in_pkt && (left_eff == LW'(1));

  // packet and fill state
  always_comb begin
    pkt_factor_nxt = pkt_factor_r;
    pkt_dir_nxt    = pkt_dir_r;
    left_nxt       = left_r;
    fill_nxt       = fill_r;
    rows3_nxt      = rows3_r;
    drain_pl_nxt   = drain_pl_r;
    state_nxt      = state_r;
    if (in_fire) begin
      pkt_factor_nxt = f_eff;
      pkt_dir_nxt    = dir_eff;
      left_nxt       = in_pkt ? left_eff - LW'(1) : left_eff;
      rows3_nxt      = group_done ? 1'b0 : rows3_eff;
      if (group_done) begin
        fill_nxt     = '0;
        drain_pl_nxt = pass_last;
        state_nxt    = ST_DRAIN;
      end else if (take_group) begin
        fill_nxt = fill_eff + 4'd1;
      end else begin
        fill_nxt = fill_eff;
      end
    end else if (issue && ag_stat.last) begin
      state_nxt = ST_FILL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pkt_factor_r <= FACTOR_RESET;
      pkt_dir_r    <= 1'b0;
      left_r       <= '0;
      fill_r       <= '0;
      rows3_r      <= 1'b0;
      drain_pl_r   <= 1'b0;
      state_r      <= ST_FILL;
    end else begin
      pkt_factor_r <= pkt_factor_nxt;
      pkt_dir_r    <= pkt_dir_nxt;
      left_r       <= left_nxt;
      fill_r       <= fill_nxt;
      rows3_r      <= rows3_nxt;
      drain_pl_r   <= drain_pl_nxt;
      state_r      <= state_nxt;
    end
  end

  // group store
  assign mem_we = in_fire && take_group;

  sint_group_mem #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (fill_eff),
    .wdata (in_chan.sample),
    .re    (issue),
    .raddr (ag_stat.addr),
    .rdata (mem_rdata)
  );

  // read address sequencing
  assign ag_ctrl.load  = in_fire && group_done;
  assign ag_ctrl.step  = issue;
  assign ag_ctrl.f4    = (f_eff == FACTOR_FOUR);
  assign ag_ctrl.rows3 = rows3_eff;
  assign ag_ctrl.dir   = dir_eff;

  sint_addr_gen u_ag (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (ag_ctrl),
    .stat  (ag_stat)
  );

  // read in flight
  always_comb begin
    if (issue) begin
      pend_nxt = 1'b1;
    end else if (pend_take) begin
      pend_nxt = 1'b0;
    end else begin
      pend_nxt = pend_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      pend_last_r <= ag_stat.last;
    end
  end

  // output register
  assign out_v_nxt = (in_fire && !take_group) || pend_take ||
                     (out_v_r && !out_chan.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && !take_group) begin
      out_data_r <= in_chan.sample;
      out_gl_r   <= pass_last;
      out_pl_r   <= pass_last;
    end else if (pend_take) begin
      out_data_r <= mem_rdata;
      out_gl_r   <= pend_last_r;
      out_pl_r   <= pend_last_r && drain_pl_r;
    end
  end

  assign in_chan.ready        = in_ready;
  assign out_chan.valid       = out_v_r;
  assign out_chan.sample_out  = out_data_r;
  assign out_chan.group_last  = out_gl_r;
  assign out_chan.packet_last = out_pl_r;

  // checks
  a_no_write_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == ST_FILL) && !pend_r)
    else $error("group store written during read-out");

  a_group_starts_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && group_done) |=> (state_r == ST_DRAIN) && (fill_r == '0))
    else $error("completed group did not start read-out");

  a_last_read_ends_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_take && pend_last_r) |=> (state_r == ST_FILL))
    else $error("read-out still active after last symbol of group");

endmodule

>>> rtl/sint_group_mem.sv
// Group store: 12-entry synchronous memory, one write and one read port,
// read data registered and held while no read is issued. Depends on sint_pkg.
module sint_group_mem import sint_pkg::*; #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                    clk,
  input  logic                    we,
  input  logic [ADDR_W-1:0]       waddr,
  input  logic [SAMPLE_WIDTH-1:0] wdata,
  input  logic                    re,
  input  logic [ADDR_W-1:0]       raddr,
  output logic [SAMPLE_WIDTH-1:0] rdata
);

  logic [SAMPLE_WIDTH-1:0] mem [BUF_DEPTH];
  logic [SAMPLE_WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/sint_addr_gen.sv
// Read address sequencer for group read-out. Walks address K*i + j with
// i counting modulo M and j the wrap count. Depends on sint_pkg.
module sint_addr_gen import sint_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  ag_ctrl_t ctrl,
  output ag_stat_t stat
);

  logic [1:0]        i_r, i_nxt;
  logic [1:0]        j_r, j_nxt;
  logic [ADDR_W-1:0] cnt_r, cnt_nxt;
  logic [CFG_W-1:0]  mod_r, mod_nxt;   // inner modulus
  logic [CFG_W-1:0]  mul_r, mul_nxt;   // stride of inner count
  logic [ADDR_W-1:0] last_r, last_nxt; // group size minus one
  logic [CFG_W-1:0]  fac, rows;

  assign fac  = ctrl.f4 ? FACTOR_FOUR : FACTOR_TWO;
  assign rows = ctrl.rows3 ? ROWS_THREE : ROWS_TWO;

  // counter update: interleave strides by F over R rows, deinterleave the reverse
  always_comb begin
    i_nxt    = i_r;
    j_nxt    = j_r;
    cnt_nxt  = cnt_r;
    mod_nxt  = mod_r;
    mul_nxt  = mul_r;
    last_nxt = last_r;
    if (ctrl.load) begin
      i_nxt    = 2'd0;
      j_nxt    = 2'd0;
      cnt_nxt  = '0;
      mod_nxt  = ctrl.dir ? fac : rows;
      mul_nxt  = ctrl.dir ? rows : fac;
      last_nxt = group_size(ctrl.f4, ctrl.rows3) - 4'd1;
    end else if (ctrl.step) begin
      cnt_nxt = cnt_r + 4'd1;
      if ({1'b0, i_r} == mod_r - 3'd1) begin
        i_nxt = 2'd0;
        j_nxt = j_r + 2'd1;
      end else begin
        i_nxt = i_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r   <= 2'd0;
      j_r   <= 2'd0;
      cnt_r <= '0;
    end else begin
      i_r   <= i_nxt;
      j_r   <= j_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // group shape, loaded per read-out
  always_ff @(posedge clk) begin
    mod_r  <= mod_nxt;
    mul_r  <= mul_nxt;
    last_r <= last_nxt;
  end

  assign stat.addr = ADDR_W'({1'b0, mul_r} * {2'b00, i_r}) + {2'b00, j_r};
  assign stat.last = (cnt_r == last_r);

endmodule
